/* sv/tsve_pkg.sv */
package tsve_pkg;

  localparam int IdBitsDefault = 32;
  localparam int MaxBytes      = 9;
  localparam int QueueDepth    = 2;

  typedef enum logic [2:0] {
    KIND_BOOL   = 3'd0,
    KIND_NULL   = 3'd1,
    KIND_BYTE   = 3'd2,
    KIND_INT    = 3'd3,
    KIND_DOUBLE = 3'd4,
    KIND_LIST   = 3'd5,
    KIND_OBJECT = 3'd6,
    KIND_NONE   = 3'd7
  } kind_t;

  localparam logic [7:0] TagTrue     = 8'hFF;
  localparam logic [7:0] TagFalse    = 8'hFE;
  localparam logic [7:0] TagNull     = 8'hFC;
  localparam logic [7:0] TagByte     = 8'hFD;
  localparam logic [7:0] TagPosSmall = 8'hC0;
  localparam logic [7:0] TagNegSmall = 8'hD0;
  localparam logic [7:0] TagPosLarge = 8'hF0;
  localparam logic [7:0] TagNegLarge = 8'hF4;
  localparam logic [7:0] TagSingle   = 8'hF8;
  localparam logic [7:0] TagDouble   = 8'hF9;
  localparam logic [7:0] TagListSh   = 8'hA0;
  localparam logic [7:0] TagObjSh    = 8'h80;
  localparam logic [7:0] TagListLong = 8'hBF;
  localparam logic [7:0] TagObjLong  = 8'h9F;
  localparam logic [7:0] VarLenMark  = 8'h80;

  // One classified item: a header byte, an optional second byte, and a body
  // of little-endian bytes.
  typedef struct packed {
    logic [7:0]  head;
    logic        has_second;
    logic [7:0]  second;
    logic [3:0]  body_len;
    logic [63:0] body;
  } enc_t;

endpackage

/* sv/tsve_front.sv */
module tsve_front
  import tsve_pkg::*;
#(
  parameter int IdBits = IdBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic [2:0]  kind,
  input  logic [63:0] payload,
  output logic        in_ready,
  output logic        enc_valid,
  output enc_t        enc,
  input  logic        enc_take
);

  localparam logic [63:0] IdLimit = 64'h00FF_FFFF_FFFF_FFFF;

  // Stage-one registers hold the item and a few precomputed flags.
  logic        s1_valid;
  logic [2:0]  s1_kind;
  logic [63:0] s1_payload;
  logic [63:0] s1_mag;
  logic [63:0] s1_id;
  logic        s1_neg;
  logic        s1_in_range;

  logic [63:0] mag_c;
  logic [63:0] id_c;
  logic        s1_adv;

  // Stage-two register is the classified item.
  logic        s2_valid;
  enc_t        s2_enc;
  enc_t        enc_c;

  // Single-precision rounding.
  logic [10:0] dexp;
  logic [51:0] dman;
  logic [31:0] fbits;
  logic signed [12:0] uexp;
  logic [53:0] sig;
  logic [5:0]  shamt;
  logic [53:0] shifted;
  logic        sticky;
  logic        guard;
  logic [24:0] kept;
  logic [24:0] rnd;
  logic [30:0] mag31;
  logic [3:0]  nb;

  assign in_ready  = !s1_valid || s1_adv;
  assign s1_adv    = !s2_valid || enc_take;
  assign enc_valid = s2_valid;
  assign enc       = s2_enc;

  always_comb begin
    mag_c = payload[63] ? (64'd0 - payload) : payload;
    if (IdBits < 64) begin
      id_c = payload & ((64'd1 << IdBits) - 64'd1);
    end else begin
      id_c = payload;
    end
    if (id_c > IdLimit) begin
      id_c = IdLimit;
    end
  end

  // Stage one: capture and take the magnitude and the masked id.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      s1_kind     <= kind;
      s1_payload  <= payload;
      s1_mag      <= mag_c;
      s1_id       <= id_c;
      s1_neg      <= payload[63];
      // Range check on the magnitude: exponent below 127 fits, exponent 127
      // fits while the mantissa is not above the single maximum.
      s1_in_range <= (payload[62:52] < 11'd1150) ||
                     ((payload[62:52] == 11'd1150) && (payload[51:29] == 23'h7FFFFF) &&
                      (payload[28:0] == 29'd0)) ||
                     ((payload[62:52] == 11'd1150) && (payload[51:29] != 23'h7FFFFF));
    end
  end

  // Double to single, nearest even.
  always_comb begin
    dexp  = s1_payload[62:52];
    dman  = s1_payload[51:0];
    uexp  = $signed({2'b00, dexp}) - 13'sd896;
    sig   = {1'b0, (dexp != 11'd0), dman};
    fbits = 32'd0;
    shamt = 6'd0;
    shifted = 54'd0;
    sticky = 1'b0;
    guard  = 1'b0;
    kept   = 25'd0;
    rnd    = 25'd0;
    mag31  = 31'd0;
    if (uexp >= 13'sd1) begin
      // Normal single: keep 24 bits of significand. A carry out of the
      // significand moves into the exponent.
      kept   = {1'b0, sig[52:29]};
      guard  = sig[28];
      sticky = |sig[27:0];
      rnd    = kept + {24'd0, guard && (sticky || kept[0])};
      mag31  = {uexp[7:0], 23'd0} + 31'(rnd) - 31'h0080_0000;
    end else if (uexp >= -13'sd24) begin
      // Subnormal single: shift right by 1 - uexp more places.
      shamt   = 6'(13'sd1 - uexp);
      shifted = sig >> shamt;
      sticky  = |(sig & ((54'd1 << shamt) - 54'd1)) || (|shifted[27:0]);
      kept    = {1'b0, shifted[52:29]};
      guard   = shifted[28];
      rnd     = kept + {24'd0, guard && (sticky || kept[0])};
      mag31   = {7'd0, rnd[23:0]};
    end else begin
      mag31 = 31'd0;
    end
    fbits = {s1_payload[63], mag31};
  end

  always_comb begin
    nb = 4'd1;
    for (int i = 1; i < 8; i++) begin
      if (s1_id[8*i +: 8] != 8'd0) begin
        nb = 4'(i + 1);
      end
    end
  end

  // Classification into header, optional second byte and body.
  always_comb begin
    enc_c = '0;
    unique case (kind_t'(s1_kind))
      KIND_BOOL: enc_c.head = s1_payload[0] ? TagTrue : TagFalse;
      KIND_NULL: enc_c.head = TagNull;
      KIND_BYTE: begin
        enc_c.head     = TagByte;
        enc_c.body_len = 4'd1;
        enc_c.body     = {56'd0, s1_payload[7:0]};
      end
      KIND_INT: begin
        enc_c.body = s1_mag;
        if (s1_mag < 64'd16) begin
          enc_c.head = (s1_neg ? TagNegSmall : TagPosSmall) | {4'd0, s1_mag[3:0]};
        end else if (s1_mag <= 64'hFF) begin
          enc_c.head = s1_neg ? TagNegLarge : TagPosLarge;
          enc_c.body_len = 4'd1;
        end else if (s1_mag <= 64'hFFFF) begin
          enc_c.head = (s1_neg ? TagNegLarge : TagPosLarge) | 8'd1;
          enc_c.body_len = 4'd2;
        end else if (s1_mag <= 64'hFFFF_FFFF) begin
          enc_c.head = (s1_neg ? TagNegLarge : TagPosLarge) | 8'd2;
          enc_c.body_len = 4'd4;
        end else begin
          enc_c.head = (s1_neg ? TagNegLarge : TagPosLarge) | 8'd3;
          enc_c.body_len = 4'd8;
        end
      end
      KIND_DOUBLE: begin
        if (s1_in_range) begin
          enc_c.head     = TagSingle;
          enc_c.body_len = 4'd4;
          enc_c.body     = {32'd0, fbits};
        end else begin
          enc_c.head     = TagDouble;
          enc_c.body_len = 4'd8;
          enc_c.body     = s1_payload;
        end
      end
      KIND_LIST, KIND_OBJECT: begin
        if (s1_id < 64'd31) begin
          enc_c.head = ((s1_kind == KIND_LIST) ? TagListSh : TagObjSh) |
                       {3'd0, s1_id[4:0]};
        end else begin
          enc_c.head       = (s1_kind == KIND_LIST) ? TagListLong : TagObjLong;
          enc_c.has_second = 1'b1;
          if (s1_id < 64'd128) begin
            enc_c.second = s1_id[7:0];
          end else begin
            enc_c.second   = VarLenMark | {4'd0, nb};
            enc_c.body_len = nb;
            enc_c.body     = s1_id;
          end
        end
      end
      default: enc_c = '0;
    endcase
  end

  // Stage two: unused kinds are dropped here.
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_adv) begin
      s2_valid <= s1_valid && (s1_kind != KIND_NONE);
    end
    if (s1_adv) begin
      s2_enc <= enc_c;
    end
  end

endmodule

/* sv/tsve_queue.sv */
module tsve_queue
  import tsve_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  input  enc_t wr_data,
  output logic wr_take,
  output logic rd_valid,
  output enc_t rd_data,
  input  logic rd_take
);

  // Two-entry queue between classification and byte emission.
  enc_t       slot [QueueDepth];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;

  assign wr_take  = wr_valid && (count != 2'(QueueDepth));
  assign rd_valid = (count != 2'd0);
  assign rd_data  = slot[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (wr_take) begin
        wptr <= ~wptr;
      end
      if (rd_take && rd_valid) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(wr_take) - 2'(rd_take && rd_valid);
    end
    if (wr_take) begin
      slot[wptr] <= wr_data;
    end
  end

endmodule

/* sv/tsve_back.sv */
module tsve_back
  import tsve_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  enc_t       q_data,
  output logic       q_take,
  output logic       out_valid,
  output logic [7:0] out_byte,
  output logic       last,
  input  logic       out_stall
);

  // Byte sequencer: step 0 is the head, step 1 the optional second byte,
  // then the body bytes.
  logic [3:0] step;
  logic [3:0] total;
  logic [3:0] body_idx;
  logic [7:0] cur;
  logic       is_last;
  logic       load;

  always_comb begin
    total = 4'd1 + 4'(q_data.has_second) + q_data.body_len;
    body_idx = step - 4'd1 - 4'(q_data.has_second);
    if (step == 4'd0) begin
      cur = q_data.head;
    end else if (q_data.has_second && step == 4'd1) begin
      cur = q_data.second;
    end else begin
      cur = q_data.body[{body_idx[2:0], 3'b000} +: 8];
    end
    is_last = (step == total - 4'd1);
    load    = q_valid && (!out_valid || !out_stall);
  end

  assign q_take = load && is_last;

  // Output register parts the queue from the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= 4'd0;
      out_valid <= 1'b0;
    end else begin
      if (!out_valid || !out_stall) begin
        out_valid <= q_valid;
      end
      if (load) begin
        step <= is_last ? 4'd0 : step + 4'd1;
      end
    end
    if (load) begin
      out_byte <= cur;
      last     <= is_last;
    end
  end

endmodule

/* sv/tagged_scalar_value_encoder.sv */
// Channel  Direction  Handshake         Fields
// in       input      in_valid/in_stall   kind, payload
// out      output     out_valid/out_stall out_byte, last
//
// An item gives one to nine bytes (none for the unused kind), one byte per
// cycle from the emitter while out_stall is low.
// The first byte of an item passes the stage-one, stage-two, queue and output registers.
// The emitter's byte rate sets throughput.
// Reset (rst, synchronous) empties the pipeline and the queue.
// Either side may stall; the two-entry queue lets the front keep working.
module tagged_scalar_value_encoder
  import tsve_pkg::*;
#(
  parameter int IdBits = IdBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] payload,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        last
);

  logic in_ready;
  logic f_valid;
  enc_t f_enc;
  logic f_take;
  logic q_valid;
  enc_t q_data;
  logic q_take;

  assign in_stall = !in_ready;

  tsve_front #(.IdBits(IdBits)) u_front (
    .clk(clk), .rst(rst), .in_valid(in_valid), .kind(kind), .payload(payload),
    .in_ready(in_ready), .enc_valid(f_valid), .enc(f_enc), .enc_take(f_take)
  );

  tsve_queue u_queue (
    .clk(clk), .rst(rst), .wr_valid(f_valid), .wr_data(f_enc), .wr_take(f_take),
    .rd_valid(q_valid), .rd_data(q_data), .rd_take(q_take)
  );

  tsve_back u_back (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_data(q_data), .q_take(q_take),
    .out_valid(out_valid), .out_byte(out_byte), .last(last), .out_stall(out_stall)
  );

endmodule

/* tb/sv/tsve_scoreboard.sv */
`timescale 1ns / 1ps

// Watches both channels of the encoder, predicts the byte stream of every
// accepted item and compares it with the bytes that leave the block.
module tsve_scoreboard
  import tsve_pkg::*;
#(
  parameter int IdBits = IdBitsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  kind,
  input  logic [63:0] payload,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte,
  input  logic        last,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [7:0] value;
    logic       is_last;
  } enc_byte_t;

  localparam logic [63:0] IdCeiling = 64'h00FF_FFFF_FFFF_FFFF;
  localparam logic [62:0] SingleMaxMag = 63'h47EF_FFFF_E000_0000;

  enc_byte_t expected_bytes[$];
  int        checked_bytes;

  // Rounds a double to single precision, nearest even. The caller has already
  // established that the magnitude does not exceed the largest single.
  function automatic logic [31:0] round_to_single(input logic [63:0] raw);
    int          unb_exp;
    int          shift;
    logic [63:0] sig;
    logic [63:0] quot;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] bits;
    if (raw[62:52] == 11'd0) begin
      // Double subnormals lie far below the smallest single.
      return {raw[63], 31'd0};
    end
    unb_exp = int'(raw[62:52]) - 1023;
    sig = {11'd0, 1'b1, raw[51:0]};
    shift = (unb_exp >= -126) ? 29 : -unb_exp - 97;
    if (shift > 60) shift = 60;
    quot = sig >> shift;
    rem = sig & ((64'd1 << shift) - 64'd1);
    half = 64'd1 << (shift - 1);
    if (rem > half || (rem == half && quot[0])) quot = quot + 64'd1;
    // A carry out of the mantissa moves into the exponent on its own.
    if (unb_exp >= -126) bits = (32'(unb_exp + 126) << 23) + quot[31:0];
    else bits = quot[31:0];
    return {raw[63], bits[30:0]};
  endfunction

  // Appends one byte at the end of the list.
  function automatic void add_byte(inout logic [7:0] buf_q[$], input logic [7:0] b);
    buf_q.insert(buf_q.size(), b);
  endfunction

  // Appends count bytes of v, least significant first.
  function automatic void put_le(inout logic [7:0] buf_q[$], input logic [63:0] v,
                                 input int count);
    for (int i = 0; i < count; i++) add_byte(buf_q, v[8*i +: 8]);
  endfunction

  // Builds the complete tagged encoding of one scalar value.
  function automatic void encode_value(input logic [2:0] k, input logic [63:0] p,
                                       output logic [7:0] enc[$]);
    logic        neg;
    logic [63:0] mag;
    logic [7:0]  tag;
    logic [63:0] id;
    logic        is_list;
    int          nb;
    enc = {};
    case (kind_t'(k))
      KIND_BOOL: add_byte(enc, p[0] ? TagTrue : TagFalse);
      KIND_NULL: add_byte(enc, TagNull);
      KIND_BYTE: begin
        add_byte(enc, TagByte);
        add_byte(enc, p[7:0]);
      end
      KIND_INT: begin
        neg = p[63];
        mag = neg ? (64'd0 - p) : p;
        if (mag < 64'd16) begin
          add_byte(enc, (neg ? TagNegSmall : TagPosSmall) | mag[7:0]);
        end else begin
          tag = neg ? TagNegLarge : TagPosLarge;
          if (mag <= 64'hFF) begin
            add_byte(enc, tag);
            put_le(enc, mag, 1);
          end else if (mag <= 64'hFFFF) begin
            add_byte(enc, tag | 8'd1);
            put_le(enc, mag, 2);
          end else if (mag <= 64'hFFFF_FFFF) begin
            add_byte(enc, tag | 8'd2);
            put_le(enc, mag, 4);
          end else begin
            add_byte(enc, tag | 8'd3);
            put_le(enc, mag, 8);
          end
        end
      end
      KIND_DOUBLE: begin
        if (p[62:0] <= SingleMaxMag) begin
          add_byte(enc, TagSingle);
          put_le(enc, {32'd0, round_to_single(p)}, 4);
        end else begin
          add_byte(enc, TagDouble);
          put_le(enc, p, 8);
        end
      end
      KIND_LIST, KIND_OBJECT: begin
        is_list = (kind_t'(k) == KIND_LIST);
        id = p;
        if (IdBits < 64) id = id & ((64'd1 << IdBits) - 64'd1);
        if (id > IdCeiling) id = IdCeiling;
        if (id < 64'd31) begin
          add_byte(enc, (is_list ? TagListSh : TagObjSh) | id[7:0]);
        end else begin
          add_byte(enc, is_list ? TagListLong : TagObjLong);
          if (id < 64'd128) begin
            add_byte(enc, id[7:0]);
          end else begin
            nb = 0;
            for (logic [63:0] t = id; t != 64'd0; t = t >> 8) nb++;
            add_byte(enc, VarLenMark | 8'(nb));
            put_le(enc, id, nb);
          end
        end
      end
      default: ;
    endcase
  endfunction

  // Predict on every accepted input item, check every accepted output byte.
  always @(posedge clk) begin
    logic [7:0] enc[$];
    enc_byte_t  want;
    if (rst) begin
      expected_bytes.delete();
      fail_count <= 0;
      checked_bytes <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        encode_value(kind, payload, enc);
        foreach (enc[i]) begin
          want.value   = enc[i];
          want.is_last = (i == enc.size() - 1);
          expected_bytes.insert(expected_bytes.size(), want);
        end
      end
      if (out_valid && !out_stall) begin
        checked_bytes <= checked_bytes + 1;
        if (expected_bytes.size() == 0) begin
          $error("unexpected byte: out_byte=%02h last=%0b", out_byte, last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_bytes.pop_front();
          if (out_byte !== want.value) begin
            $error("out_byte mismatch: expected %02h, actual %02h", want.value, out_byte);
            fail_count <= fail_count + 1;
          end else if (last !== want.is_last) begin
            $error("last mismatch: expected %0b, actual %0b", want.is_last, last);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
    pending <= expected_bytes.size();
  end

endmodule

/* tb/sv/tagged_scalar_value_encoder_tb.sv */
`timescale 1ns / 1ps

module tagged_scalar_value_encoder_tb;
  import tsve_pkg::*;

  localparam int CycleLimit = 200000;
  localparam int RandomItems = 90;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [2:0]  kind;
  logic [63:0] payload;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  out_byte;
  logic        last;
  int          fail_count;
  int          pending;
  int          cycle_count;
  int          items_sent;
  logic        long_hold_req;
  logic        quiet;

  tagged_scalar_value_encoder u_dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .payload(payload), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last(last)
  );

  tsve_scoreboard u_scoreboard (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .kind(kind),
    .payload(payload), .out_valid(out_valid), .out_stall(out_stall),
    .out_byte(out_byte), .last(last), .fail_count(fail_count), .pending(pending)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Presents one item and holds it until the block takes it.
  task automatic send_item(input kind_t k, input logic [63:0] p);
    in_valid <= 1'b1;
    kind <= k;
    payload <= p;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (!quiet && !long_hold_req && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // Random payloads spread over the size classes of each kind.
  task automatic send_random();
    kind_t       k;
    logic [63:0] p;
    int          sel;
    k = kind_t'($urandom_range(0, 7));
    p = rand64();
    sel = $urandom_range(0, 4);
    case (k)
      KIND_INT: begin
        case (sel)
          0: p = p & 64'hF;
          1: p = p & 64'hFF;
          2: p = p & 64'hFFFF;
          3: p = p & 64'hFFFF_FFFF;
          default: ;
        endcase
        if ($urandom_range(0, 1) == 1) p = 64'd0 - p;
      end
      KIND_DOUBLE: begin
        // Exponents around the single range, its subnormals and beyond.
        case (sel)
          0: p[62:52] = 11'(1023 + $urandom_range(0, 130) - 65);
          1: p[62:52] = 11'(1023 - 150 + $urandom_range(0, 30));
          2: p[62:52] = 11'(1023 + 127 + $urandom_range(0, 1));
          3: p[28:0] = {1'b1, 28'd0};
          default: ;
        endcase
      end
      KIND_LIST, KIND_OBJECT: begin
        case (sel)
          0: p = p & 64'h1F;
          1: p = p & 64'h7F;
          2: p = p & 64'hFFFF;
          default: ;
        endcase
      end
      default: ;
    endcase
    send_item(k, p);
  endtask

  task automatic wait_drained();
    while (pending != 0) @(posedge clk);
  endtask

  // Output side: random stall bursts, calm stretches, and one long hold.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (long_hold_req) begin
        out_stall <= 1'b1;
        repeat (200) @(posedge clk);
        out_stall <= 1'b0;
        long_hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_stall <= 1'b0;
      end else begin
        repeat ($urandom_range(1, 20)) @(posedge clk);
      end
    end
  end

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    kind = '0;
    payload = '0;
    cycle_count = 0;
    items_sent = 0;
    long_hold_req = 1'b0;
    quiet = 1'b0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed: field extremes and every kind, with its special cases.
    send_item(KIND_BOOL, 64'hFFFF_FFFF_FFFF_FFFE);
    send_item(KIND_BOOL, 64'h0000_0000_0000_0001);
    send_item(KIND_NULL, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(KIND_BYTE, 64'h0000_0000_0000_00FF);
    send_item(KIND_INT, 64'd15);
    send_item(KIND_INT, 64'd16);
    send_item(KIND_INT, -64'sd15);
    send_item(KIND_INT, -64'sd16);
    send_item(KIND_INT, 64'd65536);
    send_item(KIND_INT, 64'hFFFF_FFFF);
    send_item(KIND_INT, 64'h7FFF_FFFF_FFFF_FFFF);
    // The most negative integer takes the eight-byte form.
    send_item(KIND_INT, 64'h8000_0000_0000_0000);
    send_item(KIND_DOUBLE, 64'h3FF0_0000_0000_0000);
    send_item(KIND_DOUBLE, 64'h47EF_FFFF_E000_0000);
    send_item(KIND_DOUBLE, 64'hC7EF_FFFF_E000_0001);
    send_item(KIND_DOUBLE, 64'h7FF0_0000_0000_0000);
    send_item(KIND_DOUBLE, 64'hFFF8_0000_0000_0001);
    send_item(KIND_DOUBLE, 64'h3FF0_0000_1000_0000);
    send_item(KIND_DOUBLE, 64'h3690_0000_0000_0001);
    // A mantissa of all ones rounds up into the next exponent.
    send_item(KIND_DOUBLE, 64'h3FFF_FFFF_F000_0000);
    send_item(KIND_LIST, 64'd30);
    send_item(KIND_LIST, 64'd127);
    send_item(KIND_OBJECT, 64'd31);
    send_item(KIND_OBJECT, 64'hFFFF_FFFF_FFFF_FFFF);
    // An unused kind gives no bytes at all.
    send_item(KIND_NONE, 64'h5555_AAAA_5555_AAAA);

    // The receiver holds off while items keep coming.
    long_hold_req = 1'b1;
    while (long_hold_req) send_random();

    // The sender waits until everything has come out.
    in_valid <= 1'b0;
    wait_drained();
    repeat (10) @(posedge clk);

    for (int i = 0; i < RandomItems; i++) begin
      if (i == RandomItems - 25) quiet = 1'b1;
      send_random();
    end

    in_valid <= 1'b0;
    wait_drained();
    repeat (20) @(posedge clk);

    $display("tb: sent %0d items of all kinds, with stalls on both sides and a long hold",
             items_sent);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
